### rtl/lrs_pkg.sv
// ---------------------------------------------------------------------------
// lrs_pkg - shared types and constants of the LRU recency stack
// Codes, cell link structs and controller state for the cell row.
// ---------------------------------------------------------------------------
package lrs_pkg;

  localparam int unsigned LRS_DEPTH  = 64;
  localparam int unsigned LRS_DATA_W = 32;
  localparam int unsigned LRS_OP_W   = 2;
  localparam int unsigned LRS_STAT_W = 3;
  localparam int unsigned LRS_OCC_W  = 7;
  localparam int unsigned LRS_CFG_W  = 7;

  localparam logic [LRS_CFG_W-1:0] LRS_MAX_SIZE_RST = 7'd64;

  // opcodes
  localparam logic [LRS_OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [LRS_OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [LRS_OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [LRS_OP_W-1:0] OP_LOOKUP = 2'd3;

  // result status codes
  localparam logic [LRS_STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [LRS_STAT_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [LRS_STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [LRS_STAT_W-1:0] STAT_ON_TOP    = 3'd3;
  localparam logic [LRS_STAT_W-1:0] STAT_FULL      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } lrs_state_e;

  // commands broadcast to every cell
  typedef struct packed {
    logic cmp;        // compare value against entry, seed scan flags
    logic scan;       // one doubling step of the suffix OR
    logic load;       // push into the first free cell
    logic shift_all;  // every cell takes its upper neighbor (pop)
    logic shift_rm;   // cells at or above the match take their upper neighbor
  } lrs_ctrl_t;

  // content handed from a cell to the one below
  typedef struct packed {
    logic                  valid;
    logic [LRS_DATA_W-1:0] entry;
  } lrs_link_t;

  // scan flags: s = a match at or above, t = the top entry matches at or above
  typedef struct packed {
    logic s;
    logic t;
  } lrs_scan_t;

endpackage

### rtl/lrs_cell.sv
// ---------------------------------------------------------------------------
// lrs_cell - one position of the recency stack
// Holds an entry with its valid bit and the match flags of the current scan.
// ---------------------------------------------------------------------------
module lrs_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lrs_pkg::lrs_ctrl_t                ctrl_i,
  input  logic [lrs_pkg::LRS_DATA_W-1:0]    value_i,
  input  lrs_pkg::lrs_link_t                up_link_i,
  input  lrs_pkg::lrs_scan_t                up_scan_i,
  input  lrs_pkg::lrs_scan_t                far_i,
  input  logic                              below_valid_i,
  output lrs_pkg::lrs_link_t                link_o,
  output lrs_pkg::lrs_scan_t                scan_o
);

  logic [lrs_pkg::LRS_DATA_W-1:0] entry_q, entry_d;
  logic                           valid_q, valid_d;
  lrs_pkg::lrs_scan_t             scan_q, scan_d;
  logic                           match;
  logic                           is_top;
  logic                           take_up;
  logic                           load;

  always_comb begin
    match   = valid_q && (entry_q == value_i);
    is_top  = valid_q && !up_link_i.valid;
    // close the gap: on a remove, only cells with no match above them move
    take_up = ctrl_i.shift_all || (ctrl_i.shift_rm && !up_scan_i.s);
    load    = ctrl_i.load && !valid_q && below_valid_i;

    entry_d = entry_q;
    valid_d = valid_q;
    if (take_up) begin
      entry_d = up_link_i.entry;
      valid_d = up_link_i.valid;
    end else if (load) begin
      entry_d = value_i;
      valid_d = 1'b1;
    end

    scan_d = scan_q;
    if (ctrl_i.cmp) begin
      scan_d.s = match;
      scan_d.t = match && is_top;
    end else if (ctrl_i.scan) begin
      scan_d.s = scan_q.s | far_i.s;
      scan_d.t = scan_q.t | far_i.t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      valid_q <= valid_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.entry = entry_q;
  assign scan_o       = scan_q;

endmodule

### rtl/lru_recency_stack_unit.sv
// ---------------------------------------------------------------------------
// lru_recency_stack_unit - bounded LRU recency stack of page numbers
// Row of cells, bottom = oldest; push, pop oldest, remove and lookup.
// ---------------------------------------------------------------------------
// Takes one item at a time. Push and pop are captured, then applied in an
// update of the cell row that registers the result. For remove and lookup
// every cell compares in the capture cycle, then the match flags spread
// down the row by a doubling suffix OR, one step per cycle, to find the
// match nearest the top and to tell whether it is the top entry, before
// the result is registered. A finished result sits in the output register
// while the next item is taken; the row waits only if that register is
// still full when the next result is ready. max_size is the limit, capped
// at DEPTH; lowering it drops no entry.
module lru_recency_stack_unit #(
  parameter int unsigned DEPTH = lrs_pkg::LRS_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,     // max_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] value
  input  logic [1:0]  s_axis_tuser,    // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // [31:0] value_out, [32] hit, [39:33] occupancy,
                                       // [40] is_empty, [41] is_full, rest zero
  output logic [2:0]  m_axis_tuser     // [2:0] status
);

  localparam int unsigned Log  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned LimW = (CntW > lrs_pkg::LRS_CFG_W) ? CntW : lrs_pkg::LRS_CFG_W;
  localparam logic [LimW-1:0] DepthL = LimW'(DEPTH);

  lrs_pkg::lrs_state_e state_q, state_d;

  logic [lrs_pkg::LRS_CFG_W-1:0]  max_size_q;
  logic [lrs_pkg::LRS_OP_W-1:0]   op_q;
  logic [lrs_pkg::LRS_DATA_W-1:0] value_q;
  logic [Log-1:0]                 dist_q;
  logic [CntW-1:0]                count_q, count_d;

  logic                           out_valid_q;
  logic [lrs_pkg::LRS_STAT_W-1:0] out_status_q, status_d;
  logic [lrs_pkg::LRS_DATA_W-1:0] out_value_q, vout_d;
  logic                           out_hit_q, hit_d;
  logic [lrs_pkg::LRS_OCC_W-1:0]  out_occ_q, occ_d;
  logic                           out_empty_q, empty_d;
  logic                           out_full_q, full_d;

  logic                           accept;
  logic                           fire;
  logic [LimW-1:0]                lim;
  logic [LimW-1:0]                cnt_l;
  logic [LimW-1:0]                cnt_next_l;
  logic                           found;
  logic                           on_top;

  lrs_pkg::lrs_ctrl_t             ctrl;
  logic [lrs_pkg::LRS_DATA_W-1:0] cell_value;

  lrs_pkg::lrs_link_t             link   [DEPTH];
  lrs_pkg::lrs_scan_t             scan   [DEPTH];
  lrs_pkg::lrs_scan_t             far    [DEPTH];
  lrs_pkg::lrs_scan_t             far_opt[DEPTH][Log];
  logic [DEPTH-1:0]               valid_vec;

  assign s_axis_tready = (state_q == lrs_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == lrs_pkg::ST_APPLY) && (!out_valid_q || m_axis_tready);

  // ---------------- cell row ----------------
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    for (genvar gk = 0; gk < Log; gk++) begin : g_far
      localparam int unsigned Far = gi + (1 << gk);
      if (Far < DEPTH) begin : g_in
        assign far_opt[gi][gk] = dist_q[gk] ? scan[Far] : '0;
      end else begin : g_out
        assign far_opt[gi][gk] = '0;
      end
    end

    always_comb begin
      far[gi] = '0;
      for (int k = 0; k < Log; k++) begin
        far[gi] = far[gi] | far_opt[gi][k];
      end
    end

    lrs_pkg::lrs_link_t up_link;
    lrs_pkg::lrs_scan_t up_scan;
    logic               below_valid;

    if (gi == DEPTH - 1) begin : g_top
      assign up_link = '0;
      assign up_scan = '0;
    end else begin : g_mid
      assign up_link = link[gi+1];
      assign up_scan = scan[gi+1];
    end

    if (gi == 0) begin : g_bot
      assign below_valid = 1'b1;
    end else begin : g_above
      assign below_valid = link[gi-1].valid;
    end

    lrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .value_i      (cell_value),
      .up_link_i    (up_link),
      .up_scan_i    (up_scan),
      .far_i        (far[gi]),
      .below_valid_i(below_valid),
      .link_o       (link[gi]),
      .scan_o       (scan[gi])
    );

    assign valid_vec[gi] = link[gi].valid;
  end

  // compare against the incoming value in the transfer cycle
  assign cell_value = (state_q == lrs_pkg::ST_IDLE) ? s_axis_tdata : value_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrs_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser inside {lrs_pkg::OP_PUSH, lrs_pkg::OP_POP}) begin
            state_d = lrs_pkg::ST_APPLY;
          end else begin
            state_d = lrs_pkg::ST_SCAN;
          end
        end
      end
      lrs_pkg::ST_SCAN: begin
        if (dist_q[Log-1]) begin
          state_d = lrs_pkg::ST_APPLY;
        end
      end
      lrs_pkg::ST_APPLY: begin
        if (fire) begin
          state_d = lrs_pkg::ST_IDLE;
        end
      end
      default: state_d = lrs_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs of the controller ----------------
  always_comb begin
    lim        = (LimW'(max_size_q) > DepthL) ? DepthL : LimW'(max_size_q);
    cnt_l      = LimW'(count_q);
    found      = scan[0].s;
    on_top     = scan[0].t;

    ctrl       = '0;
    ctrl.cmp   = accept;
    ctrl.scan  = (state_q == lrs_pkg::ST_SCAN);

    count_d    = count_q;
    status_d   = lrs_pkg::STAT_OK;
    vout_d     = '0;
    hit_d      = 1'b0;

    case (op_q)
      lrs_pkg::OP_PUSH: begin
        if (cnt_l >= lim) begin
          status_d = lrs_pkg::STAT_FULL;
        end else begin
          ctrl.load = fire;
          count_d   = count_q + CntW'(1);
        end
      end
      lrs_pkg::OP_POP: begin
        if (count_q == '0) begin
          status_d = lrs_pkg::STAT_EMPTY;
        end else begin
          vout_d         = link[0].entry;
          ctrl.shift_all = fire;
          count_d        = count_q - CntW'(1);
        end
      end
      lrs_pkg::OP_REMOVE: begin
        if (count_q == '0) begin
          status_d = lrs_pkg::STAT_EMPTY;
        end else if (on_top) begin
          status_d = lrs_pkg::STAT_ON_TOP;
          hit_d    = 1'b1;
        end else if (found) begin
          vout_d        = value_q;
          hit_d         = 1'b1;
          ctrl.shift_rm = fire;
          count_d       = count_q - CntW'(1);
        end else begin
          status_d = lrs_pkg::STAT_NOT_FOUND;
        end
      end
      lrs_pkg::OP_LOOKUP: begin
        if (found) begin
          hit_d = 1'b1;
        end else begin
          status_d = lrs_pkg::STAT_NOT_FOUND;
        end
      end
      default: status_d = lrs_pkg::STAT_OK;
    endcase

    cnt_next_l = LimW'(count_d);
    occ_d      = lrs_pkg::LRS_OCC_W'(count_d);
    empty_d    = (count_d == '0);
    full_d     = (cnt_next_l >= lim);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrs_pkg::ST_IDLE;
      max_size_q  <= lrs_pkg::LRS_MAX_SIZE_RST;
      count_q     <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      if (fire) begin
        count_q <= count_d;
      end
      // advance the doubling distance of the scan
      if (accept) begin
        dist_q <= Log'(1);
      end else if (state_q == lrs_pkg::ST_SCAN) begin
        dist_q <= dist_q << 1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      value_q <= s_axis_tdata;
    end
    if (fire) begin
      out_status_q <= status_d;
      out_value_q  <= vout_d;
      out_hit_q    <= hit_d;
      out_occ_q    <= occ_d;
      out_empty_q  <= empty_d;
      out_full_q   <= full_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, out_full_q, out_empty_q, out_occ_q, out_hit_q, out_value_q};

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LimW'(count_q) <= DepthL)
    else $error("occupancy beyond stack depth");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("valid cells not packed from the bottom");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'($countones(valid_vec)) == count_q)
    else $error("valid cells disagree with occupancy");

  a_apply_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (state_q == lrs_pkg::ST_IDLE))
    else $error("result not registered after update");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the LRU recency stack unit
// Sends push, pop, remove and lookup transfers under random idling and back
// pressure, keeps its own copy of the stack and limit, and compares every
// field of every result against that copy or against a directed table row.
// ---------------------------------------------------------------------------
module tb_top;
  import lrs_pkg::*;

  localparam int unsigned CLK_HALF    = 2;
  localparam int unsigned WATCH_MAX   = 5000;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned ITEM_TARGET = 1800;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned NUM_DIR     = 24;

  typedef struct packed {
    logic [LRS_STAT_W-1:0] status;
    logic [LRS_DATA_W-1:0] value_out;
    logic                  hit;
    logic [LRS_OCC_W-1:0]  occupancy;
    logic                  is_empty;
    logic                  is_full;
  } outcome_t;

  typedef enum logic {
    ROW_XFER,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [LRS_OP_W-1:0]   op;
    logic [LRS_DATA_W-1:0] value;
    logic [LRS_CFG_W-1:0]  limit;
    logic                  typed;
    outcome_t              exp;
  } dir_row_t;

  localparam outcome_t NO_EXP = '0;

  // walk of empty, top, duplicate, full and lowered-limit cases
  localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
    '{ROW_XFER, OP_POP, 32'h0, 7'd0, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 7'd0, 1'b1, 1'b0}},
    '{ROW_XFER, OP_REMOVE, 32'h5, 7'd0, 1'b1,
      '{STAT_EMPTY, 32'h0, 1'b0, 7'd0, 1'b1, 1'b0}},
    '{ROW_XFER, OP_LOOKUP, 32'h0, 7'd0, 1'b1,
      '{STAT_NOT_FOUND, 32'h0, 1'b0, 7'd0, 1'b1, 1'b0}},
    '{ROW_XFER, OP_PUSH, 32'h0, 7'd0, 1'b1, '{STAT_OK, 32'h0, 1'b0, 7'd1, 1'b0, 1'b0}},
    '{ROW_XFER, OP_PUSH, 32'hFFFF_FFFF, 7'd0, 1'b1,
      '{STAT_OK, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0}},
    '{ROW_XFER, OP_REMOVE, 32'hFFFF_FFFF, 7'd0, 1'b1,
      '{STAT_ON_TOP, 32'h0, 1'b1, 7'd2, 1'b0, 1'b0}},
    '{ROW_XFER, OP_LOOKUP, 32'h0, 7'd0, 1'b1, '{STAT_OK, 32'h0, 1'b1, 7'd2, 1'b0, 1'b0}},
    '{ROW_XFER, OP_LOOKUP, 32'hFFFF_FFFE, 7'd0, 1'b0, NO_EXP},
    '{ROW_XFER, OP_REMOVE, 32'h1234_5678, 7'd0, 1'b1,
      '{STAT_NOT_FOUND, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0}},
    '{ROW_XFER, OP_PUSH, 32'h0, 7'd0, 1'b0, NO_EXP},
    '{ROW_XFER, OP_PUSH, 32'hAAAA_AAAA, 7'd0, 1'b0, NO_EXP},
    '{ROW_XFER, OP_REMOVE, 32'h0, 7'd0, 1'b0, NO_EXP},
    '{ROW_XFER, OP_POP, 32'h0, 7'd0, 1'b0, NO_EXP},
    '{ROW_LIMIT, OP_PUSH, 32'h0, 7'd2, 1'b0, NO_EXP},
    '{ROW_XFER, OP_PUSH, 32'h5555_5555, 7'd0, 1'b1,
      '{STAT_FULL, 32'h0, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{ROW_LIMIT, OP_PUSH, 32'h0, 7'd1, 1'b0, NO_EXP},
    '{ROW_XFER, OP_PUSH, 32'h1, 7'd0, 1'b1, '{STAT_FULL, 32'h0, 1'b0, 7'd2, 1'b0, 1'b1}},
    '{ROW_XFER, OP_REMOVE, 32'hFFFF_FFFF, 7'd0, 1'b1,
      '{STAT_OK, 32'hFFFF_FFFF, 1'b1, 7'd1, 1'b0, 1'b1}},
    '{ROW_LIMIT, OP_PUSH, 32'h0, 7'd0, 1'b0, NO_EXP},
    '{ROW_XFER, OP_PUSH, 32'h3, 7'd0, 1'b1, '{STAT_FULL, 32'h0, 1'b0, 7'd1, 1'b0, 1'b1}},
    '{ROW_XFER, OP_POP, 32'h0, 7'd0, 1'b1,
      '{STAT_OK, 32'hAAAA_AAAA, 1'b0, 7'd0, 1'b1, 1'b1}},
    '{ROW_XFER, OP_PUSH, 32'h3, 7'd0, 1'b1, '{STAT_FULL, 32'h0, 1'b0, 7'd0, 1'b1, 1'b1}},
    '{ROW_LIMIT, OP_PUSH, 32'h0, 7'd64, 1'b0, NO_EXP},
    '{ROW_XFER, OP_LOOKUP, 32'hAAAA_AAAA, 7'd0, 1'b0, NO_EXP}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // software copy of the stack, bottom (oldest) at index 0
  logic [LRS_DATA_W-1:0] stack_pages[$];
  logic [LRS_CFG_W-1:0]  size_limit;
  outcome_t              pending_results[$];

  int unsigned err_count     = 0;
  int unsigned items_in      = 0;
  int unsigned results_out   = 0;
  int unsigned limits_set    = 0;
  int unsigned full_refusals = 0;
  int unsigned top_hits      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_ask      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  bit          quiet         = 1'b0;

  lru_recency_stack_unit #(
    .DEPTH(LRS_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic outcome_t predict_stack(logic [LRS_OP_W-1:0] op,
                                             logic [LRS_DATA_W-1:0] v);
    outcome_t o;
    int       cap;
    int       pos;
    int       i;
    o   = '0;
    cap = (size_limit > LRS_DEPTH) ? LRS_DEPTH : int'(size_limit);
    pos = -1;
    case (op)
      OP_PUSH: begin
        if (stack_pages.size() >= cap) o.status = STAT_FULL;
        else stack_pages.push_back(v);
      end
      OP_POP: begin
        if (stack_pages.size() == 0) o.status = STAT_EMPTY;
        else o.value_out = stack_pages.pop_front();
      end
      OP_REMOVE: begin
        if (stack_pages.size() == 0) begin
          o.status = STAT_EMPTY;
        end else if (stack_pages[stack_pages.size()-1] == v) begin
          o.status = STAT_ON_TOP;
          o.hit    = 1'b1;
        end else begin
          // take the match nearest the top
          for (i = stack_pages.size() - 1; i >= 0 && pos < 0; i--)
            if (stack_pages[i] == v) pos = i;
          if (pos >= 0) begin
            o.value_out = stack_pages[pos];
            o.hit       = 1'b1;
            stack_pages.delete(pos);
          end else begin
            o.status = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        for (i = 0; i < stack_pages.size(); i++)
          if (stack_pages[i] == v) o.hit = 1'b1;
        if (!o.hit) o.status = STAT_NOT_FOUND;
      end
    endcase
    o.occupancy = LRS_OCC_W'(stack_pages.size());
    o.is_empty  = (stack_pages.size() == 0);
    o.is_full   = (stack_pages.size() >= cap);
    return o;
  endfunction

  function automatic logic [LRS_OP_W-1:0] pick_op(int unsigned mix);
    int unsigned r;
    int unsigned t_push;
    int unsigned t_pop;
    int unsigned t_rm;
    r = $urandom_range(99);
    case (mix)
      0:       begin t_push = 75; t_pop = 80; t_rm = 90; end  // fill
      1:       begin t_push = 20; t_pop = 50; t_rm = 80; end  // drain
      default: begin t_push = 35; t_pop = 55; t_rm = 80; end
    endcase
    if (r < t_push) return OP_PUSH;
    if (r < t_pop)  return OP_POP;
    if (r < t_rm)   return OP_REMOVE;
    return OP_LOOKUP;
  endfunction

  // bias values toward what the stack holds so removes and lookups hit
  function automatic logic [LRS_DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (stack_pages.size() != 0 && r < 30)
      return stack_pages[$urandom_range(stack_pages.size() - 1)];
    if (stack_pages.size() != 0 && r < 40) return stack_pages[stack_pages.size()-1];
    if (r < 60) return $urandom_range(15);
    if (r < 66) return r[0] ? '1 : '0;
    return $urandom();
  endfunction

  task automatic send_item(logic [LRS_OP_W-1:0] op, logic [LRS_DATA_W-1:0] v,
                           logic typed, outcome_t typed_exp);
    outcome_t pred;
    if (!quiet && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_stack(op, v);
    pending_results.push_back(typed ? typed_exp : pred);
    items_in++;
    if (pred.status == STAT_FULL)   full_refusals++;
    if (pred.status == STAT_ON_TOP) top_hits++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [LRS_CFG_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    size_limit  = v;
    limits_set++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[39:33],
              m_axis_tdata[40], m_axis_tdata[41]};
      results_out++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("[%0t] result with nothing pending: status %0d value %h", $realtime,
                   got.status, got.value_out);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[47:42] !== '0) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("[%0t] mismatch exp: st %0d val %h hit %0d occ %0d emp %0d ful %0d",
                     $realtime, want.status, want.value_out, want.hit, want.occupancy,
                     want.is_empty, want.is_full);
            $display("    got: st %0d val %h hit %0d occ %0d emp %0d ful %0d pad %h",
                     got.status, got.value_out, got.hit, got.occupancy, got.is_empty,
                     got.is_full, m_axis_tdata[47:42]);
          end
        end
      end
    end
  end

  // watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCH_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    int unsigned k;
    int unsigned n;
    int unsigned phase;
    size_limit = LRS_MAX_SIZE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NUM_DIR; k++) begin
      row = DIR_TABLE[k];
      if (row.kind == ROW_LIMIT) set_limit(row.limit);
      else send_item(row.op, row.value, row.typed, row.exp);
    end

    phase = 0;
    while (items_in < ITEM_TARGET) begin
      case (phase % 8)
        0:       set_limit(7'd127);                  // above the cap
        1:       set_limit(7'd64);
        2:       set_limit(7'd1);
        3:       set_limit(7'($urandom_range(2, 8)));
        4:       set_limit(7'($urandom_range(1, 64)));
        5:       set_limit(7'($urandom_range(65, 126)));
        6:       set_limit(7'd0);
        default: set_limit(7'($urandom_range(9, 63)));
      endcase
      quiet = (phase == 4);
      if (phase == 5) hold_ask++;
      n = $urandom_range(60, 120);
      if (phase % 8 == 0) n = 200;
      if (phase % 8 == 6) n = 30;
      if (phase == 4) n = 160;
      for (k = 0; k < n; k++) begin
        if (phase == 9 && k == n / 2) wait_drained();
        send_item(pick_op(phase % 3), pick_value(), 1'b0, NO_EXP);
      end
      phase++;
    end
    quiet = 1'b0;
    wait_drained();

    $display("Covered %0d transfers in, %0d results out, %0d limit settings from 0 to 127.",
             items_in, results_out, limits_set);
    $display("Refused pushes: %0d, removes of the top entry: %0d, mismatches: %0d.",
             full_refusals, top_hits, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### lru_recency_stack_unit.f
rtl/lrs_pkg.sv
rtl/lrs_cell.sv
rtl/lru_recency_stack_unit.sv
bench/tb_top.sv
